FILE: rtl/core/uwa_pkg.sv
// ----------------------------------------------------------------------------
// uwa_pkg: shared definitions for the adjacency store
// Operation codes, fixed field widths and the control and status bundles
// passed between the sequencer and the row scan unit.
// ----------------------------------------------------------------------------
package uwa_pkg;

    localparam int VERT_W   = 4;
    localparam int WEIGHT_W = 32;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_DEL   = 2'd1;
    localparam logic [1:0] KIND_FIRST = 2'd2;
    localparam logic [1:0] KIND_NEXT  = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic hit;
        logic empty;
    } scan_stat_t;

endpackage

FILE: rtl/core/uwa_ram.sv
// ----------------------------------------------------------------------------
// uwa_ram: single-port memory with registered read
// One access per cycle: a write, or a read whose data appears next cycle.
// ----------------------------------------------------------------------------
module uwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/uwa_scan.sv
// ----------------------------------------------------------------------------
// uwa_scan: row scan unit
// Holds one adjacency row shifted down to the current column and walks it
// one column per step until the lowest set bit reaches position zero.
// ----------------------------------------------------------------------------
module uwa_scan #(
    parameter int NUM_VERTICES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  uwa_pkg::scan_ctrl_t             ctrl,
    input  logic [NUM_VERTICES-1:0]         row_in,
    input  logic [$clog2(NUM_VERTICES)-1:0] start,
    output uwa_pkg::scan_stat_t             stat,
    output logic [$clog2(NUM_VERTICES)-1:0] col
);

    localparam int VW = $clog2(NUM_VERTICES);

    logic [NUM_VERTICES-1:0] row_reg;
    logic [VW-1:0]           col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (ctrl.load)
        begin
            row_reg <= row_in >> start;
            col_reg <= start;
        end
        else if (ctrl.step)
        begin
            row_reg <= row_reg >> 1;
            col_reg <= col_reg + VW'(1);
        end
    end

    assign stat.hit   = row_reg[0];
    assign stat.empty = (row_reg == '0);
    assign col        = col_reg;

endmodule

FILE: rtl/core/undirected_weighted_adjacency_store.sv
// ----------------------------------------------------------------------------
// undirected_weighted_adjacency_store: undirected weighted graph storage
// Adjacency bitmap (one row per vertex) plus a weight memory, driven by a
// small sequencer around a shared row scan unit.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one operation per transfer:
// set edge, delete edge, first edge or next edge. The output channel
// (out_valid, out_stall) carries one result per query; set and delete give
// no result. One operation is worked on at a time and in_stall is high
// until it is finished.
// Set and delete work on each direction in turn: each direction is a read
// and a write of one bitmap row on the single port of the bitmap memory,
// plus, for set, the weight write alongside. With a vertex out of range
// they are dropped and the next transfer can follow in the next cycle.
// A query that finds a neighbor goes through row read, scan load, the scan
// from the start column up to that neighbor, weight read and result load.
// The result is presented in the same cycle as the next transfer can happen.
// After reset the bitmap is cleared one row per cycle, with in_stall high.
// When the receiver stalls, the finished result waits in the output register
// and the next operation is still accepted; its result waits for the register
// to empty.
// ----------------------------------------------------------------------------
module undirected_weighted_adjacency_store #(
    parameter int NUM_VERTICES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic [uwa_pkg::VERT_W-1:0]         vertex_a,
    input  logic [uwa_pkg::VERT_W-1:0]         vertex_b,
    input  logic signed [uwa_pkg::WEIGHT_W-1:0] weight_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [uwa_pkg::VERT_W-1:0]         from_vertex,
    output logic [uwa_pkg::VERT_W-1:0]         to_vertex,
    output logic signed [uwa_pkg::WEIGHT_W-1:0] edge_weight
);

    localparam int VW    = $clog2(NUM_VERTICES);
    localparam int CELLS = NUM_VERTICES * NUM_VERTICES;
    localparam int AW    = $clog2(CELLS);

    // Sequencer states.
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD_A  = 4'd2;
    localparam logic [3:0] ST_MOD_A = 4'd3;
    localparam logic [3:0] ST_RD_B  = 4'd4;
    localparam logic [3:0] ST_MOD_B = 4'd5;
    localparam logic [3:0] ST_LOAD  = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_WRD   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // Weight memory address of the entry at (row, column).
    function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r,
                                                input logic [VW-1:0] c);
        return AW'(int'(r) * NUM_VERTICES + int'(c));
    endfunction

    logic [3:0]                  state_reg, state_next;
    logic [VW-1:0]               clr_reg, clr_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [uwa_pkg::VERT_W-1:0]  a_reg, a_next;
    logic [uwa_pkg::VERT_W-1:0]  b_reg, b_next;
    logic [uwa_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic                        hit_reg, hit_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic [uwa_pkg::VERT_W-1:0]  from_reg, from_next;
    logic [uwa_pkg::VERT_W-1:0]  to_reg, to_next;
    logic [uwa_pkg::WEIGHT_W-1:0] wt_reg, wt_next;

    logic                        accept;
    logic                        a_ok, b_ok, start_ok;
    logic                        out_free;
    logic [VW-1:0]               idx_a, idx_b;
    logic [VW-1:0]               scan_start;
    logic [NUM_VERTICES-1:0]     bit_a, bit_b;

    logic                        row_we;
    logic [VW-1:0]               row_addr;
    logic [NUM_VERTICES-1:0]     row_wdata, row_rdata;

    logic                        wt_we;
    logic [AW-1:0]               wt_addr;
    logic [uwa_pkg::WEIGHT_W-1:0] wt_rdata;

    uwa_pkg::scan_ctrl_t         scan_ctrl;
    uwa_pkg::scan_stat_t         scan_stat;
    logic [VW-1:0]               scan_col;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Range checks on the incoming vertex numbers.
    assign a_ok     = {28'd0, vertex_a} < 32'(NUM_VERTICES);
    assign b_ok     = {28'd0, vertex_b} < 32'(NUM_VERTICES);
    assign start_ok = ({28'd0, vertex_b} + 32'd1) < 32'(NUM_VERTICES);

    assign idx_a = VW'(a_reg);
    assign idx_b = VW'(b_reg);
    assign bit_a = NUM_VERTICES'(1) << idx_a;
    assign bit_b = NUM_VERTICES'(1) << idx_b;

    // A next-edge query starts one column above the previous neighbor.
    assign scan_start = (kind_reg == uwa_pkg::KIND_FIRST) ? '0 : idx_b + VW'(1);

    // Bitmap port: clearing pass, then row read and write back per direction.
    always_comb
    begin
        row_we    = 1'b0;
        row_addr  = idx_a;
        row_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                row_we   = 1'b1;
                row_addr = clr_reg;
            end
            ST_MOD_A:
            begin
                row_we    = 1'b1;
                row_wdata = (kind_reg == uwa_pkg::KIND_SET) ? (row_rdata | bit_b)
                                                            : (row_rdata & ~bit_b);
            end
            ST_RD_B:
            begin
                row_addr = idx_b;
            end
            ST_MOD_B:
            begin
                row_we    = 1'b1;
                row_addr  = idx_b;
                row_wdata = (kind_reg == uwa_pkg::KIND_SET) ? (row_rdata | bit_a)
                                                            : (row_rdata & ~bit_a);
            end
            default:
            begin
                row_addr = idx_a;
            end
        endcase
    end

    // Weight port: writes during set, otherwise the address follows the
    // scan column so the read data stays put until the result is loaded.
    always_comb
    begin
        wt_we   = 1'b0;
        wt_addr = cell_addr(idx_a, scan_col);
        case (state_reg)
            ST_MOD_A:
            begin
                wt_we   = (kind_reg == uwa_pkg::KIND_SET);
                wt_addr = cell_addr(idx_a, idx_b);
            end
            ST_MOD_B:
            begin
                wt_we   = (kind_reg == uwa_pkg::KIND_SET);
                wt_addr = cell_addr(idx_b, idx_a);
            end
            default:
            begin
                wt_addr = cell_addr(idx_a, scan_col);
            end
        endcase
    end

    assign scan_ctrl.load = (state_reg == ST_LOAD);
    assign scan_ctrl.step = (state_reg == ST_SCAN) && !scan_stat.hit && !scan_stat.empty;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        kind_next      = kind_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        wt_next        = wt_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + VW'(1);
                if (clr_reg == VW'(NUM_VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind;
                    a_next    = vertex_a;
                    b_next    = vertex_b;
                    w_next    = weight_in;
                    hit_next  = 1'b0;
                    if (kind == uwa_pkg::KIND_SET || kind == uwa_pkg::KIND_DEL)
                    begin
                        if (a_ok && b_ok)
                        begin
                            state_next = ST_RD_A;
                        end
                    end
                    else if (a_ok && (kind == uwa_pkg::KIND_FIRST || start_ok))
                    begin
                        state_next = ST_RD_A;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD_A:
            begin
                if (kind_reg == uwa_pkg::KIND_SET || kind_reg == uwa_pkg::KIND_DEL)
                begin
                    state_next = ST_MOD_A;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_MOD_A:
            begin
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                state_next = ST_MOD_B;
            end
            ST_MOD_B:
            begin
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_stat.hit)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_WRD;
                end
                else if (scan_stat.empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WRD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    from_next      = a_reg;
                    to_next        = hit_reg ? uwa_pkg::VERT_W'(scan_col) : '0;
                    wt_next        = hit_reg ? wt_rdata : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        w_reg     <= w_next;
        found_reg <= found_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        wt_reg    <= wt_next;
    end

    uwa_ram #(
        .WIDTH (NUM_VERTICES),
        .DEPTH (NUM_VERTICES)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (row_wdata),
        .rdata (row_rdata)
    );

    uwa_ram #(
        .WIDTH (uwa_pkg::WEIGHT_W),
        .DEPTH (CELLS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wt_we),
        .addr  (wt_addr),
        .wdata (w_reg),
        .rdata (wt_rdata)
    );

    uwa_scan #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .row_in (row_rdata),
        .start  (scan_start),
        .stat   (scan_stat),
        .col    (scan_col)
    );

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign from_vertex = from_reg;
    assign to_vertex   = to_reg;
    assign edge_weight = wt_reg;

endmodule
